[rtl/fcfs_pkg.sv]
// Shared types and constants for the first-come-first-served schedule calculator.
// Holds the request, response and table entry layouts; depends on nothing else.
package fcfs_pkg;

   // Width of all schedule times (wait and finish).
   localparam int TIME_W = 21;

   // One process descriptor as loaded by the host.
   typedef struct packed {
      logic [7:0]  proc_id;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
      logic        last;
   } req_type;

   // One scheduled process as reported to the host.
   typedef struct packed {
      logic [7:0]        out_id;
      logic [15:0]       out_arrival;
      logic [15:0]       out_burst;
      logic [TIME_W-1:0] wait_time;
      logic [TIME_W-1:0] finish_time;
      logic              dropped;
      logic              out_last;
   } rsp_type;

   // One stored entry of the process table.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] arrival;
      logic [15:0] burst;
   } entry_type;

endpackage

[rtl/fcfs_schedule_calculator.sv]
// Loading accepts an item whenever start is high and busy is low. A closing item keeps busy
// high through the exchange sort over the table RAM, which takes one compare per pair and
// reads, holds and writes back each outer row, and then through one result per cycle.
// The single-port table read and the one shared compare set how long busy stays high.
// Results are one-cycle strobes that the receiver cannot stall; the last result coincides
// with busy falling. Synchronous active-high reset empties the batch and returns to loading.
//
// Top level of the schedule calculator: table RAM, sort sequencer and schedule pass.
// Depends on fcfs_pkg for the request, response and entry types.
module fcfs_schedule_calculator #(
   parameter int MAX_PROCS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fcfs_pkg::req_type req_data,
   output logic             rsp_valid,
   output fcfs_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int TW    = fcfs_pkg::TIME_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SORT_READ,
      ST_SORT_HOLD,
      ST_SORT_CMP,
      ST_SORT_WB,
      ST_RUN_READ,
      ST_RUN_OUT
   } state_type;

   // Control and payload registers.
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_W-1:0]    a_ff, a_in;
   logic [IDX_W-1:0]    b_ff, b_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [TW-1:0]       cur_ff, cur_in;
   fcfs_pkg::entry_type hold_ff, hold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   fcfs_pkg::rsp_type   rsp_ff, rsp_in;

   // Table RAM: one write port and one registered read port.
   fcfs_pkg::entry_type mem [MAX_PROCS];
   fcfs_pkg::entry_type rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   fcfs_pkg::entry_type mem_wd;

   // Schedule arithmetic on the entry just read.
   logic [TW-1:0] arr_ext;
   logic [TW-1:0] begin_time;
   logic [TW-1:0] wait_val;
   logic [TW-1:0] finish_val;

   logic             accept;
   logic             full;
   logic [CNT_W-1:0] a_next;
   logic [CNT_W-1:0] b_next;
   logic [CNT_W-1:0] k_next;

   assign accept = start && (state_ff == ST_LOAD);
   assign full   = (cnt_ff == CNT_W'(MAX_PROCS));
   assign a_next = CNT_W'(a_ff) + CNT_W'(1);
   assign b_next = CNT_W'(b_ff) + CNT_W'(1);
   assign k_next = CNT_W'(k_ff) + CNT_W'(1);

   // The processor idles up to the arrival if it is free earlier.
   assign arr_ext    = TW'(rd_data_ff.arrival);
   assign begin_time = (cur_ff < arr_ext) ? arr_ext : cur_ff;
   assign wait_val   = begin_time - arr_ext;
   assign finish_val = begin_time + TW'(rd_data_ff.burst);

   // Sequencer: loading, exchange sort with the outer entry held in a register, schedule.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      hold_in      = hold_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = a_ff;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff[IDX_W-1:0];
      mem_wd       = hold_ff;

      unique case (state_ff)
         ST_LOAD: begin
            mem_wd = '{id: req_data.proc_id, arrival: req_data.arrival_time,
                       burst: req_data.burst_time};
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_data.last) begin
                  a_in     = '0;
                  state_in = ST_SORT_READ;
               end
            end
         end

         ST_SORT_READ: begin
            // Outer index done once it reaches the last row.
            rd_addr = a_ff;
            if (a_next >= cnt_ff) begin
               k_in     = '0;
               state_in = ST_RUN_READ;
            end else begin
               state_in = ST_SORT_HOLD;
            end
         end

         ST_SORT_HOLD: begin
            hold_in  = rd_data_ff;
            rd_addr  = a_next[IDX_W-1:0];
            b_in     = a_next[IDX_W-1:0];
            state_in = ST_SORT_CMP;
         end

         ST_SORT_CMP: begin
            // Swap the held entry with row b when it arrives later.
            rd_addr = b_next[IDX_W-1:0];
            if (hold_ff.arrival > rd_data_ff.arrival) begin
               mem_we  = 1'b1;
               mem_wa  = b_ff;
               mem_wd  = hold_ff;
               hold_in = rd_data_ff;
            end
            if (b_next == cnt_ff) begin
               state_in = ST_SORT_WB;
            end else begin
               b_in = b_next[IDX_W-1:0];
            end
         end

         ST_SORT_WB: begin
            mem_we   = 1'b1;
            mem_wa   = a_ff;
            mem_wd   = hold_ff;
            a_in     = a_next[IDX_W-1:0];
            state_in = ST_SORT_READ;
         end

         ST_RUN_READ: begin
            rd_addr  = k_ff;
            cur_in   = '0;
            state_in = ST_RUN_OUT;
         end

         ST_RUN_OUT: begin
            // One result per cycle while the next row is being read.
            rd_addr      = k_next[IDX_W-1:0];
            cur_in       = finish_val;
            rsp_valid_in = 1'b1;
            rsp_in       = '{out_id: rd_data_ff.id, out_arrival: rd_data_ff.arrival,
                             out_burst: rd_data_ff.burst, wait_time: wait_val,
                             finish_time: finish_val, dropped: ovf_ff,
                             out_last: (k_next == cnt_ff)};
            if (k_next == cnt_ff) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               cur_in   = '0;
               k_in     = '0;
               state_in = ST_LOAD;
            end else begin
               k_in = k_next[IDX_W-1:0];
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         a_ff         <= '0;
         b_ff         <= '0;
         k_ff         <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         k_ff         <= k_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   // Table RAM write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign busy      = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A result only follows a cycle in which the block was working on a batch.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a batch in progress");

   // The fill count never passes the table depth.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PROCS))
      else $error("entry count beyond table depth");

   // A closing item always starts the sort and schedule.
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last) |=> busy)
      else $error("closing item did not start the batch");

   // The final result of a batch hands control back to loading.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_last) |-> !busy)
      else $error("block still busy after the final result");
`endif

endmodule

[tb/fcfs_schedule_calculator_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the first-come-first-served schedule calculator.
// Depends on fcfs_pkg and fcfs_schedule_calculator; a scoreboard class predicts each batch.
module fcfs_schedule_calculator_test;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 270;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int TIME_W       = fcfs_pkg::TIME_W;

   // Kinds of random batch content.
   typedef enum int {
      BATCH_DENSE,
      BATCH_SPARSE,
      BATCH_EQUAL,
      BATCH_EXTREME
   } batch_kind_type;

   // Predicts the schedule of each batch and checks the reported items against it.
   class fcfs_scoreboard;
      fcfs_pkg::entry_type batch_table[TABLE_DEPTH];
      int unsigned         stored;
      bit                  lost_items;
      fcfs_pkg::rsp_type   schedule_q[$];
      int unsigned         error_count;

      function new();
         stored = 0;
         lost_items = 1'b0;
         error_count = 0;
      endfunction

      // Stores an accepted item if there is room; a closing item works out the whole schedule.
      function void note_item(fcfs_pkg::req_type it);
         fcfs_pkg::entry_type swap_entry;
         logic [TIME_W-1:0]   clock_now;
         fcfs_pkg::rsp_type   slot;
         if (stored < TABLE_DEPTH) begin
            batch_table[stored].id = it.proc_id;
            batch_table[stored].arrival = it.arrival_time;
            batch_table[stored].burst = it.burst_time;
            stored++;
         end else begin
            lost_items = 1'b1;
         end
         if (!it.last)
            return;
         // Exchange sort on arrival; equal arrivals stay as this sort leaves them.
         for (int a = 0; a + 1 < stored; a++) begin
            for (int b = a + 1; b < stored; b++) begin
               if (batch_table[a].arrival > batch_table[b].arrival) begin
                  swap_entry = batch_table[a];
                  batch_table[a] = batch_table[b];
                  batch_table[b] = swap_entry;
               end
            end
         end
         // Run the processes in order, idling up to an arrival when the processor is free.
         clock_now = '0;
         for (int k = 0; k < stored; k++) begin
            if (clock_now < TIME_W'(batch_table[k].arrival))
               clock_now = TIME_W'(batch_table[k].arrival);
            slot.out_id = batch_table[k].id;
            slot.out_arrival = batch_table[k].arrival;
            slot.out_burst = batch_table[k].burst;
            slot.wait_time = clock_now - TIME_W'(batch_table[k].arrival);
            clock_now = clock_now + TIME_W'(batch_table[k].burst);
            slot.finish_time = clock_now;
            slot.dropped = lost_items;
            slot.out_last = (k + 1 == stored);
            schedule_q.push_back(slot);
         end
         stored = 0;
         lost_items = 1'b0;
      endfunction

      function void check_field(string field_name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
            error_count++;
         end
      endfunction

      // Compares a reported item with the oldest predicted one.
      function void check_result(fcfs_pkg::rsp_type got);
         fcfs_pkg::rsp_type want;
         if (schedule_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            error_count++;
            return;
         end
         want = schedule_q.pop_front();
         check_field("out_id", want.out_id, got.out_id);
         check_field("out_arrival", want.out_arrival, got.out_arrival);
         check_field("out_burst", want.out_burst, got.out_burst);
         check_field("wait_time", want.wait_time, got.wait_time);
         check_field("finish_time", want.finish_time, got.finish_time);
         check_field("dropped", want.dropped, got.dropped);
         check_field("out_last", want.out_last, got.out_last);
      endfunction

      function int unsigned outstanding();
         return schedule_q.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   fcfs_pkg::req_type  req_data = '0;
   logic               rsp_valid;
   fcfs_pkg::rsp_type  rsp_data;

   fcfs_scoreboard sb = new();
   int unsigned    idle_cycles = 0;
   int unsigned    items_sent = 0;
   bit             gaps_enabled = 1'b1;

   fcfs_schedule_calculator #(
      .MAX_PROCS(TABLE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Monitor: check reported items first, then note an accepted item.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid)
            sb.check_result(rsp_data);
         if (start && !busy)
            sb.note_item(req_data);
         if (rsp_valid || (start && !busy))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic fcfs_pkg::req_type noise_item();
      fcfs_pkg::req_type r;
      r.proc_id = 8'($urandom);
      r.arrival_time = 16'($urandom);
      r.burst_time = 16'($urandom);
      r.last = 1'($urandom);
      return r;
   endfunction

   // Mostly no gap, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99, 0);
      if (!gaps_enabled || roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 8);
   endfunction

   // Presents one item after an optional gap and waits until it is accepted.
   task automatic send_item(input fcfs_pkg::req_type it, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         req_data <= noise_item();
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= it;
      do
         @(posedge clock);
      while (busy);
      items_sent++;
   endtask

   // Lowers start and holds off until every predicted item has been reported.
   task automatic drain_schedule();
      @(negedge clock);
      start <= 1'b0;
      req_data <= noise_item();
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   function automatic fcfs_pkg::req_type make_item(logic [7:0] id, logic [15:0] arr,
                                                   logic [15:0] run, logic is_last);
      fcfs_pkg::req_type r;
      r.proc_id = id;
      r.arrival_time = arr;
      r.burst_time = run;
      r.last = is_last;
      return r;
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(2, 0))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one random batch of the given size and kind; the final item closes it.
   task automatic send_batch(input int count, input batch_kind_type kind);
      logic [15:0] arr;
      logic [15:0] run;
      logic [15:0] shared_arrival;
      shared_arrival = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         case (kind)
            BATCH_DENSE: begin
               arr = 16'($urandom_range(30, 0));
               run = 16'($urandom_range(12, 0));
            end
            BATCH_SPARSE: begin
               arr = 16'($urandom);
               run = 16'($urandom_range(2000, 0));
            end
            BATCH_EQUAL: begin
               arr = shared_arrival;
               run = 16'($urandom);
            end
            default: begin
               arr = pick_extreme();
               run = pick_extreme();
            end
         endcase
         send_item(make_item(8'($urandom), arr, run, i == count - 1), pick_gap());
      end
   endtask

   initial begin
      int             batch_size;
      int             roll;
      int unsigned    batch_number;
      batch_kind_type kind;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A batch of one, with every field at its top value.
      send_item(make_item(8'hFF, 16'hFFFF, 16'hFFFF, 1'b1), 0);
      // Zero arrival and run time, tied arrivals after idling, a late arrival that must wait.
      send_item(make_item(8'h00, 16'd10, 16'd0, 1'b0), 0);
      send_item(make_item(8'h01, 16'd3, 16'hFFFF, 1'b0), 2);
      send_item(make_item(8'h02, 16'd3, 16'd1, 1'b0), 0);
      send_item(make_item(8'h55, 16'd0, 16'd0, 1'b0), 0);
      send_item(make_item(8'hAA, 16'hFFF0, 16'd2, 1'b1), 0);
      drain_schedule();
      // Full table in falling arrival order, then one item more and a closing item that
      // are both dropped for lack of room.
      for (int i = 0; i < TABLE_DEPTH + 2; i++)
         send_item(make_item(8'(i), 16'(16'hFFFF - i * 4000), 16'(i * 997),
                             i == TABLE_DEPTH + 1), 0);

      // Random batches: mostly small, some large up to a full table, a few overflowing.
      items_sent = 0;
      batch_number = 0;
      while (items_sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99, 0);
         if (roll < 80)
            batch_size = $urandom_range(8, 1);
         else if (roll < 95)
            batch_size = $urandom_range(TABLE_DEPTH, 9);
         else
            batch_size = $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH + 1);
         kind = batch_kind_type'($urandom_range(3, 0));
         gaps_enabled = ($urandom_range(3, 0) != 0);
         send_batch(batch_size, kind);
         batch_number++;
         if (batch_number % 5 == 0)
            drain_schedule();
      end

      drain_schedule();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
rtl/fcfs_pkg.sv
rtl/fcfs_schedule_calculator.sv
tb/fcfs_schedule_calculator_test.sv
